### rtl/sgp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding Goertzel power block.
// Holds the word structs, the multiplier step table and fixed widths; depends on nothing.
package sgp_pkg;

  localparam int SampleW = 24;
  localparam int DiffW   = 25;
  localparam int CoefW   = 32;
  localparam int StateW  = 64;
  localparam int PowerW  = 64;
  localparam int OpW     = 33;
  localparam int ProdW   = 66;
  localparam int P1W     = 96;
  localparam int AccW    = 160;
  localparam int SumW    = 69;
  localparam int ShiftW  = 7;
  localparam int StepW   = 4;

  // last step of the resonator product, first and last step of the power terms
  localparam logic [StepW-1:0] LastResStep    = 4'd1;
  localparam logic [StepW-1:0] FirstPowerStep = 4'd2;
  localparam logic [StepW-1:0] LastStep       = 4'd13;

  // input word
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      block_end;
  } sample_word_t;

  // result word
  typedef struct packed {
    logic [PowerW-1:0] power;
    logic              block_end_out;
  } result_word_t;

  // comb output handed from front to back
  typedef struct packed {
    logic signed [DiffW-1:0] diff;
    logic                    block_end;
  } diff_word_t;

  // multiplier operand sources (33-bit signed limbs)
  typedef enum logic [2:0] {
    OP_COEF  = 3'd0,
    OP_Z1_LO = 3'd1,
    OP_Z1_HI = 3'd2,
    OP_Z2_LO = 3'd3,
    OP_Z2_HI = 3'd4,
    OP_P1_L0 = 3'd5,
    OP_P1_L1 = 3'd6,
    OP_P1_L2 = 3'd7
  } operand_e;

  typedef struct packed {
    operand_e          op_a;
    operand_e          op_b;
    logic [ShiftW-1:0] shift;
    logic              sub;
  } mul_step_t;

  // Partial product schedule.
  // Steps 0-1: c*z1 (old state). Steps 2-7: (z1^2 + z2^2) << 30 of the new state,
  // cross terms doubled by one extra shift. Steps 8-13: subtract (c*z2)*z1.
  function automatic mul_step_t step_info(input logic [StepW-1:0] idx);
    mul_step_t s;
    case (idx)
      4'd0:    s = '{OP_COEF,  OP_Z1_LO, 7'd0,  1'b0};
      4'd1:    s = '{OP_COEF,  OP_Z1_HI, 7'd32, 1'b0};
      4'd2:    s = '{OP_Z1_LO, OP_Z1_LO, 7'd30, 1'b0};
      4'd3:    s = '{OP_Z1_LO, OP_Z1_HI, 7'd63, 1'b0};
      4'd4:    s = '{OP_Z1_HI, OP_Z1_HI, 7'd94, 1'b0};
      4'd5:    s = '{OP_Z2_LO, OP_Z2_LO, 7'd30, 1'b0};
      4'd6:    s = '{OP_Z2_LO, OP_Z2_HI, 7'd63, 1'b0};
      4'd7:    s = '{OP_Z2_HI, OP_Z2_HI, 7'd94, 1'b0};
      4'd8:    s = '{OP_P1_L0, OP_Z1_LO, 7'd0,  1'b1};
      4'd9:    s = '{OP_P1_L0, OP_Z1_HI, 7'd32, 1'b1};
      4'd10:   s = '{OP_P1_L1, OP_Z1_LO, 7'd32, 1'b1};
      4'd11:   s = '{OP_P1_L1, OP_Z1_HI, 7'd64, 1'b1};
      4'd12:   s = '{OP_P1_L2, OP_Z1_LO, 7'd64, 1'b1};
      4'd13:   s = '{OP_P1_L2, OP_Z1_HI, 7'd96, 1'b1};
      default: s = '{OP_COEF,  OP_COEF,  7'd0,  1'b0};
    endcase
    return s;
  endfunction

endpackage

### rtl/sgp_front.sv
`timescale 1ns / 1ps
// Front end: accepts samples, keeps the WINDOW-deep sample history and forms the comb difference.
// Uses sgp_pkg types; feeds sgp_fifo.
module sgp_front import sgp_pkg::*; #(
  parameter int WINDOW = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_push_i,
  output logic         in_full_o,
  input  sample_word_t in_word_i,
  output logic         q_push_o,
  input  logic         q_full_i,
  output diff_word_t   q_word_o
);

  localparam int PtrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [1:0] {
    FS_IDLE = 2'b01,
    FS_DIFF = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic wrapped_q, wrapped_d;
  logic signed [SampleW-1:0] sample_q;
  logic be_q;
  logic [SampleW-1:0] rd_q;
  logic [SampleW-1:0] hist_mem [WINDOW];
  logic [SampleW-1:0] old_sample;
  logic accept;
  logic wr_en;

  assign in_full_o = (state_q != FS_IDLE);
  assign accept    = in_push_i && (state_q == FS_IDLE);
  assign wr_en     = (state_q == FS_DIFF) && !q_full_i;

  // history slots not yet written since reset read as zero
  assign old_sample = wrapped_q ? rd_q : '0;

  assign q_push_o           = wr_en;
  assign q_word_o.diff      = $signed({sample_q[SampleW-1], sample_q}) -
                              $signed({old_sample[SampleW-1], old_sample});
  assign q_word_o.block_end = be_q;

  // history memory: read the oldest slot every cycle, overwrite it on push
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[ptr_q] <= sample_q;
    end
    rd_q <= hist_mem[ptr_q];
  end

  // sample capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_word_i.sample;
      be_q     <= in_word_i.block_end;
    end
  end

  // control
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    wrapped_d = wrapped_q;
    case (state_q)
      FS_IDLE: begin
        if (accept) begin
          state_d = FS_DIFF;
        end
      end
      FS_DIFF: begin
        if (wr_en) begin
          state_d = FS_IDLE;
          if (ptr_q == PtrW'(WINDOW - 1)) begin
            ptr_d     = '0;
            wrapped_d = 1'b1;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FS_IDLE;
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      wrapped_q <= wrapped_d;
    end
  end

endmodule

### rtl/sgp_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of comb words between the front and back ends.
// Uses diff_word_t from sgp_pkg.
module sgp_fifo import sgp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  diff_word_t word_i,
  input  logic       pop_i,
  output logic       empty_o,
  output diff_word_t word_o
);

  diff_word_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign word_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### rtl/sgp_back.sv
`timescale 1ns / 1ps
// Back end: resonator update and power estimate on one shared 33x33 multiplier,
// plus the result register. Uses sgp_pkg types and the step table.
module sgp_back import sgp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [CoefW-1:0] coef_i,
  input  logic                    q_empty_i,
  output logic                    q_pop_o,
  input  diff_word_t              q_word_i,
  output logic                    out_empty_o,
  input  logic                    out_pop_i,
  output result_word_t            out_word_o
);

  typedef enum logic [4:0] {
    BS_IDLE  = 5'b00001,
    BS_MUL   = 5'b00010,
    BS_DRAIN = 5'b00100,
    BS_RES   = 5'b01000,
    BS_FIN   = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic signed [DiffW-1:0] diff_q, diff_d;
  logic be_q, be_d;
  logic signed [StateW-1:0] z1_q, z1_d, z2_q, z2_d;
  logic [P1W-1:0] p1_q, p1_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [ShiftW-1:0] pshift_q;
  logic psub_q;
  logic pv_q, pv_d;
  logic [AccW-1:0] acc_q, acc_d;
  result_word_t res_q, res_d;
  logic res_vld_q, res_vld_d;

  mul_step_t step;
  logic signed [OpW-1:0] op_a, op_b;
  logic [AccW-1:0] pext, addend;
  logic signed [P1W:0] p1_rnd;
  logic [SumW-1:0] sum;
  logic [StateW-1:0] z_sat;
  logic [PowerW-1:0] power;
  logic out_free;

  function automatic logic signed [OpW-1:0] pick(input operand_e sel,
                                                  input logic [CoefW-1:0] c,
                                                  input logic [StateW-1:0] a,
                                                  input logic [StateW-1:0] b,
                                                  input logic [P1W-1:0] p);
    logic signed [OpW-1:0] v;
    case (sel)
      OP_COEF:  v = {c[CoefW-1], c};
      OP_Z1_LO: v = {1'b0, a[31:0]};
      OP_Z1_HI: v = {a[63], a[63:32]};
      OP_Z2_LO: v = {1'b0, b[31:0]};
      OP_Z2_HI: v = {b[63], b[63:32]};
      OP_P1_L0: v = {1'b0, p[31:0]};
      OP_P1_L1: v = {1'b0, p[63:32]};
      OP_P1_L2: v = {p[95], p[95:64]};
      default:  v = '0;
    endcase
    return v;
  endfunction

  // multiplier stage: one partial product per step
  assign step   = step_info(step_q);
  assign op_a   = pick(step.op_a, coef_i, z1_q, z2_q, p1_q);
  assign op_b   = pick(step.op_b, coef_i, z1_q, z2_q, p1_q);
  assign prod_d = op_a * op_b;

  // accumulate stage: sign-extend, align, add or subtract
  assign pext   = {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
  assign addend = pext << pshift_q;

  // resonator: round(c*z1 / 2^30) + diff*2^16 - z2, saturated to 64 bits
  assign p1_rnd = $signed({acc_q[P1W-1], acc_q[P1W-1:0]}) + $signed(97'h20000000);
  assign sum    = {{2{p1_rnd[P1W]}}, p1_rnd[P1W:30]}
                + {{(SumW - DiffW - 16){diff_q[DiffW-1]}}, diff_q, 16'h0000}
                - {{(SumW - StateW){z2_q[StateW-1]}}, z2_q};

  always_comb begin
    if ((sum[SumW-1:63] == '0) || (sum[SumW-1:63] == '1)) begin
      z_sat = sum[StateW-1:0];
    end else if (sum[SumW-1]) begin
      z_sat = {1'b1, {(StateW - 1){1'b0}}};
    end else begin
      z_sat = {1'b0, {(StateW - 1){1'b1}}};
    end
  end

  // power: negative clamps to zero, anything past 64 integer bits saturates
  always_comb begin
    if (acc_q[AccW-1]) begin
      power = '0;
    end else if (|acc_q[AccW-2:126]) begin
      power = '1;
    end else begin
      power = acc_q[125:62];
    end
  end

  assign out_free    = !res_vld_q || out_pop_i;
  assign out_empty_o = !res_vld_q;
  assign out_word_o  = res_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    diff_d    = diff_q;
    be_d      = be_q;
    z1_d      = z1_q;
    z2_d      = z2_q;
    p1_d      = p1_q;
    pv_d      = 1'b0;
    q_pop_o   = 1'b0;
    res_d     = res_q;
    res_vld_d = res_vld_q && !out_pop_i;
    if (pv_q) begin
      acc_d = psub_q ? (acc_q - addend) : (acc_q + addend);
    end else begin
      acc_d = acc_q;
    end
    case (state_q)
      BS_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          diff_d  = q_word_i.diff;
          be_d    = q_word_i.block_end;
          step_d  = '0;
          acc_d   = '0;
          state_d = BS_MUL;
        end
      end
      BS_MUL: begin
        pv_d   = 1'b1;
        step_d = step_q + 1'b1;
        if ((step_q == LastResStep) || (step_q == LastStep)) begin
          state_d = BS_DRAIN;
        end
      end
      BS_DRAIN: begin
        state_d = (step_q == FirstPowerStep) ? BS_RES : BS_FIN;
      end
      BS_RES: begin
        p1_d    = acc_q[P1W-1:0];
        z2_d    = z1_q;
        z1_d    = z_sat;
        acc_d   = '0;
        state_d = BS_MUL;
      end
      BS_FIN: begin
        if (out_free) begin
          res_d.power         = power;
          res_d.block_end_out = be_q;
          res_vld_d           = 1'b1;
          state_d             = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    diff_q   <= diff_d;
    be_q     <= be_d;
    p1_q     <= p1_d;
    prod_q   <= prod_d;
    pshift_q <= step.shift;
    psub_q   <= step.sub;
    acc_q    <= acc_d;
    res_q    <= res_d;
  end

  // control and resonator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_IDLE;
      step_q    <= '0;
      pv_q      <= 1'b0;
      res_vld_q <= 1'b0;
      z1_q      <= '0;
      z2_q      <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      pv_q      <= pv_d;
      res_vld_q <= res_vld_d;
      z1_q      <= z1_d;
      z2_q      <= z2_d;
    end
  end

endmodule

### rtl/sliding_goertzel_power.sv
`timescale 1ns / 1ps
// Sliding Goertzel power detector, top level.
// Instantiates sgp_front, sgp_fifo and sgp_back; uses sgp_pkg types.
//
// Input: a sample word (24-bit signed sample, block end mark) is taken at a
// clock edge with push high and full low. Results: while empty is low,
// out_word_o holds the oldest power word; pop high at an edge takes it.
// Configuration: cfg_we_i writes cfg_wdata_i into the resonator coefficient
// (2cos(w), signed Q2.30) at that edge; write it only while the block is idle.
//
// The back end runs all 14 partial products of the resonator and power terms
// through one 33x33 multiplier feeding a 160-bit accumulator, and takes no new
// word until the last one has gone into the result register. The front end
// takes a sample, then writes it into the history and pushes its comb word before
// it takes the next (history read, then write); a two-entry queue decouples it.
//
// Reset clears the resonator states, coefficient and history pointer; history
// slots read as zero until written once, so no clearing pass is needed.
// When pop stays low the result register holds; the back end waits on it and
// the queue and front end keep taking samples until they fill, then full rises.
module sliding_goertzel_power import sgp_pkg::*; #(
  parameter int WINDOW = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  sample_word_t     in_word_i,
  output logic             empty,
  input  logic             pop,
  output result_word_t     out_word_o,
  input  logic             cfg_we_i,
  input  logic [CoefW-1:0] cfg_wdata_i
);

  logic signed [CoefW-1:0] coef_q;
  logic       q_push, q_full, q_pop, q_empty;
  diff_word_t q_in, q_out;

  // coefficient register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      coef_q <= cfg_wdata_i;
    end
  end

  sgp_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_push_i (push),
    .in_full_o (full),
    .in_word_i (in_word_i),
    .q_push_o  (q_push),
    .q_full_i  (q_full),
    .q_word_o  (q_in)
  );

  sgp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .word_i  (q_in),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .word_o  (q_out)
  );

  sgp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_word_i    (q_out),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .out_word_o  (out_word_o)
  );

endmodule

### rtl/sgp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for sliding_goertzel_power, attached by bind.
// Uses sgp_pkg types; tracks words in flight from the handshakes.
module sgp_checker import sgp_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         push,
  input logic         full,
  input logic         empty,
  input logic         pop,
  input result_word_t out_word_o
);

  logic [2:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // words accepted but not yet popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 3'd0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 3'd1;
    end
  end

  // no result word without an accepted sample behind it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == 3'd0) |-> empty)
    else $error("result word shown with nothing in flight");

  // front, queue, back and result register hold five words at most
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd5)
    else $error("more words in flight than the block can hold");

  // an empty block always takes a sample
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == 3'd0) |-> !full)
    else $error("full raised with nothing in flight");

  // a waiting result word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o)))
    else $error("result word changed or vanished before pop");

endmodule

bind sliding_goertzel_power sgp_checker u_sgp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_word_o (out_word_o)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding Goertzel power block.
// Depends on sgp_pkg and sliding_goertzel_power; predicts every power word in place.
module tb_top;
  import sgp_pkg::*;

  localparam int Window = 256;

  // receiver stall patterns
  typedef enum int {
    POP_ALWAYS,
    POP_COIN,
    POP_SPARSE,
    POP_LONG_STALL
  } pop_mode_e;

  // one period of a tone at w = pi/3 (coefficient 1.0), near full scale
  localparam int TonePattern [6] = '{8388000, 4194000, -4194000, -8388000, -4194000, 4194000};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  sample_word_t     in_word_i = '0;
  logic             empty;
  logic             pop = 1'b0;
  result_word_t     out_word_o;
  logic             cfg_we_i = 1'b0;
  logic [CoefW-1:0] cfg_wdata_i = '0;

  // predictor state
  logic signed [SampleW-1:0] sample_hist [Window];
  logic [7:0]                hist_ptr;
  logic signed [StateW-1:0]  z_latest;
  logic signed [StateW-1:0]  z_prev;
  logic signed [CoefW-1:0]   coefficient;

  result_word_t power_q [$];
  int error_count = 0;
  int words_seen = 0;

  // sender burst state, receiver stall state
  int        burst_left = 0;
  int        hold_off_left = 0;
  int        stall_tick = 0;
  pop_mode_e stall_mode = POP_ALWAYS;

  sliding_goertzel_power #(.WINDOW(Window)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // Comb, resonator update and power estimate for one sample; advances the state.
  function automatic result_word_t goertzel_power_step(input sample_word_t w);
    result_word_t        r;
    logic signed [24:0]  diff;
    logic signed [191:0] cw;
    logic signed [191:0] z1w;
    logic signed [191:0] z2w;
    logic signed [191:0] dw;
    logic signed [191:0] acc;
    diff = $signed(w.sample) - $signed(sample_hist[hist_ptr]);
    sample_hist[hist_ptr] = w.sample;
    hist_ptr = hist_ptr + 8'd1;
    cw  = coefficient;
    z1w = z_latest;
    z2w = z_prev;
    dw  = diff;
    // c*z1 rounded half up to Q.16, then add the comb output and drop z2
    acc = cw * z1w + (192'sd1 <<< 29);
    acc = acc >>> 30;
    acc = acc + (dw <<< 16) - z2w;
    z_prev = z_latest;
    if (acc[191:63] == '0 || acc[191:63] == '1) begin
      z_latest = acc[63:0];
    end else begin
      z_latest = acc[191] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end
    // power in Q.62, floored to an integer and clamped to the unsigned range
    z1w = z_latest;
    z2w = z_prev;
    acc = ((z1w * z1w + z2w * z2w) <<< 30) - cw * z1w * z2w;
    if (acc[191]) begin
      r.power = '0;
    end else begin
      acc = acc >>> 62;
      r.power = (|acc[191:64]) ? '1 : acc[63:0];
    end
    r.block_end_out = w.block_end;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one word; the sender idles between bursts of random length.
  task automatic send_sample(input sample_word_t w);
    if (burst_left == 0) begin
      @(negedge clk_i);
      push = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk_i);
    push = 1'b1;
    in_word_i = w;
    do @(posedge clk_i); while (full);
    power_q.push_back(goertzel_power_step(w));
    burst_left--;
  endtask

  // Stop offering and wait until every predicted word has been taken.
  task automatic wait_for_drain();
    @(negedge clk_i);
    push = 1'b0;
    while (power_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_coefficient(input logic [CoefW-1:0] value);
    wait_for_drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    coefficient = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic sample_word_t random_sample();
    sample_word_t w;
    w.block_end = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: w.sample = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      1: w.sample = 24'($urandom_range(0, 511)) - 24'sd256;
      default: w.sample = 24'($urandom);
    endcase
    return w;
  endfunction

  // Full-scale values and block marks, reset coefficient of zero.
  task automatic test_sample_extremes();
    send_sample('{sample: 24'sh7FFFFF, block_end: 1'b0});
    send_sample('{sample: 24'sh800000, block_end: 1'b1});
    send_sample('{sample: 24'sh000000, block_end: 1'b0});
    send_sample('{sample: -24'sd1,     block_end: 1'b1});
    send_sample('{sample: 24'sd1,      block_end: 1'b0});
    send_sample('{sample: 24'sh7FFFFF, block_end: 1'b1});
    send_sample('{sample: 24'sh7FFFFF, block_end: 1'b0});
    send_sample('{sample: 24'sh800000, block_end: 1'b0});
  endtask

  // Coefficient at both ends of its range, DC and Nyquist drive.
  task automatic test_coefficient_extremes();
    write_coefficient(32'h7FFF_FFFF);
    send_sample('{sample: 24'sh7FFFFF, block_end: 1'b0});
    send_sample('{sample: 24'sh7FFFFF, block_end: 1'b0});
    send_sample('{sample: 24'sh7FFFFF, block_end: 1'b1});
    send_sample('{sample: 24'sh800000, block_end: 1'b0});
    send_sample('{sample: 24'sh000000, block_end: 1'b1});
    write_coefficient(32'h8000_0000);
    for (int i = 0; i < 8; i++) begin
      send_sample('{sample: (i % 2 == 0) ? 24'sh7FFFFF : 24'sh800000,
                    block_end: 1'(i % 2)});
    end
  endtask

  // A tone on the resonator frequency grows the power past the 64-bit limit.
  task automatic test_power_saturation();
    sample_word_t w;
    write_coefficient(32'h4000_0000);
    for (int i = 0; i < 800; i++) begin
      w.sample = 24'(TonePattern[i % 6] + int'($urandom_range(0, 510)) - 255);
      w.block_end = ($urandom_range(0, 15) == 0);
      send_sample(w);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_output_holdoff();
    hold_off_left = 400;
    for (int i = 0; i < 24; i++) send_sample(random_sample());
  endtask

  // Random samples under several coefficient settings.
  task automatic test_random_streams();
    logic [CoefW-1:0] coef_set [5];
    coef_set[0] = $urandom;
    coef_set[1] = 32'h7FFF_FFFF - 32'($urandom_range(0, 4095));
    coef_set[2] = 32'h8000_0000 + 32'($urandom_range(0, 4095));
    coef_set[3] = $urandom;
    coef_set[4] = '0;
    foreach (coef_set[k]) begin
      write_coefficient(coef_set[k]);
      for (int i = 0; i < 50; i++) send_sample(random_sample());
    end
  endtask

  // Receiver: a stall pattern drawn anew at random whenever stall_tick runs out, plus long hold-offs.
  always @(negedge clk_i) begin
    if (stall_tick == 0) begin
      stall_mode = pop_mode_e'($urandom_range(0, 3));
      stall_tick = 64;
    end
    stall_tick--;
    if (hold_off_left > 0) begin
      hold_off_left--;
      pop = 1'b0;
    end else begin
      case (stall_mode)
        POP_ALWAYS: pop = 1'b1;
        POP_COIN:   pop = 1'($urandom_range(0, 1));
        POP_SPARSE: pop = (stall_tick % 4 == 0);
        default:    pop = (stall_tick % 32 >= 24);
      endcase
    end
  end

  // Compare each taken word with the oldest prediction.
  always @(posedge clk_i) begin : check_words
    result_word_t want;
    if (pop && !empty) begin
      words_seen++;
      if (power_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d, power %0h",
                                  words_seen, out_word_o.power));
      end else begin
        want = power_q.pop_front();
        if (out_word_o.power !== want.power)
          report_mismatch($sformatf("word %0d power %0h, predicted %0h",
                                    words_seen, out_word_o.power, want.power));
        if (out_word_o.block_end_out !== want.block_end_out)
          report_mismatch($sformatf("word %0d block end %b, predicted %b",
                                    words_seen, out_word_o.block_end_out,
                                    want.block_end_out));
      end
    end
  end

  // Main sequence
  initial begin
    foreach (sample_hist[i]) sample_hist[i] = '0;
    hist_ptr = '0;
    z_latest = '0;
    z_prev = '0;
    coefficient = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_sample_extremes();
    test_coefficient_extremes();
    test_power_saturation();
    test_output_holdoff();
    test_random_streams();
    wait_for_drain();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
rtl/sgp_pkg.sv
rtl/sgp_front.sv
rtl/sgp_fifo.sv
rtl/sgp_back.sv
rtl/sliding_goertzel_power.sv
rtl/sgp_checker.sv
tb/sv/tb_top.sv
